// File: sv/chip8_pkg.sv
// shared types, codes and decode helpers for the chip8 interpreter core
package chip8_pkg;

  localparam logic [15:0] PC_RESET = 16'h0200;
  localparam logic [4:0]  NO_KEY   = 5'd16;
  localparam logic [3:0]  REG_F    = 4'hF;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_EXEC = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;
  localparam logic [1:0] KIND_COLL = 2'd3;

  localparam logic [2:0] EV_DONE  = 3'd0;
  localparam logic [2:0] EV_CLS   = 3'd1;
  localparam logic [2:0] EV_ROW   = 3'd2;
  localparam logic [2:0] EV_STACK = 3'd3;
  localparam logic [2:0] EV_WAIT  = 3'd4;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;
  localparam logic [7:0] FN_SKP   = 8'h9E;
  localparam logic [7:0] FN_SKNP  = 8'hA1;
  localparam logic [7:0] FN_GDLY  = 8'h07;
  localparam logic [7:0] FN_KEY   = 8'h0A;
  localparam logic [7:0] FN_SDLY  = 8'h15;
  localparam logic [7:0] FN_SSND  = 8'h18;
  localparam logic [7:0] FN_ADDI  = 8'h1E;
  localparam logic [7:0] FN_FONT  = 8'h29;
  localparam logic [7:0] FN_BCD   = 8'h33;
  localparam logic [7:0] FN_STORE = 8'h55;
  localparam logic [7:0] FN_LOADR = 8'h65;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_LOAD, OP_TICK, OP_COLL, OP_FETCH_HI, OP_FETCH_LO,
    OP_READ_X, OP_READ_Y, OP_EXEC, OP_RET_WB, OP_FLAG, OP_ROW_RD, OP_ROW_EMIT,
    OP_BCD, OP_STORE_RD, OP_STORE_WR, OP_LOADR_RD, OP_LOADR_WR, OP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    CLS_DONE, CLS_RET, CLS_FLAG, CLS_DRAW, CLS_BCD, CLS_STORE, CLS_LOADR
  } exec_cls_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic [15:0] opcode;
    logic        sp_zero;
    logic        cnt_is_x;
    logic        cnt_is_two;
    logic        row_last;
    logic        out_free;
  } status_t;

  function automatic exec_cls_t cls_of(input logic [15:0] op);
    exec_cls_t c;
    c = CLS_DONE;
    case (op[15:12])
      4'h0: if (op == OPC_RET) c = CLS_RET;
      4'h8: if (op[3:0] == 4'h4 || op[3:0] == 4'h5 || op[3:0] == 4'h6 ||
                op[3:0] == 4'h7 || op[3:0] == 4'hE) c = CLS_FLAG;
      4'hD: if (op[3:0] != 4'h0) c = CLS_DRAW;
      4'hF: begin
        if (op[7:0] == FN_BCD) c = CLS_BCD;
        else if (op[7:0] == FN_STORE) c = CLS_STORE;
        else if (op[7:0] == FN_LOADR) c = CLS_LOADR;
      end
      default: c = CLS_DONE;
    endcase
    return c;
  endfunction

endpackage

// File: sv/chip8_cpu_core.sv
// top level of the chip8 interpreter core
//
// channel  dir  tdata / tuser                                   tlast
// in_      in   op load, execute, tick or collision report      -
// out_     out  done, clear, sprite row, stack error, key wait  final result of a request
//
// load, tick and collision act, then emit; an instruction fetches both opcode bytes,
// reads vx and vy, executes and may write back; a draw reads and emits each row,
// FX33 writes three digits, FX55 and FX65 copy registers in turn over single read ports
// reset clears registers through per-register valid bits, no clearing pass
// a stalled output holds the core only when a new result is due
module chip8_cpu_core import chip8_pkg::*; #(
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // load_address, load_data, key_mask, random_byte
  input  logic [47:0] in_tdata,
  // kind
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // row_byte, row_number, draw_x, draw_y, program_counter, sound_on
  output logic [47:0] out_tdata,
  // event_res
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  cmd_t    cmd;
  status_t stat;

  chip8_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_kind(in_tuser), .in_tready, .stat, .cmd
  );

  chip8_dp #(.MEM_BYTES(MEM_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("core ready right after a request");

  a_non_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_ROW |-> out_tlast)
    else $error("non-row result without tlast");

  a_non_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_ROW |-> out_tdata[27:0] == 28'h0)
    else $error("non-row result carries sprite fields");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:45] == 3'b000)
    else $error("padding bits set");

endmodule

// File: sv/chip8_ram.sv
// generic simple dual-port ram with registered read
module chip8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/chip8_ctrl.sv
// sequencing state machine of the chip8 interpreter core
module chip8_ctrl import chip8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_kind,
  output logic       in_tready,
  input  status_t    stat,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_TICK, S_COLL, S_F_HI, S_F_LO, S_RD_X, S_RD_Y, S_EXEC,
    S_RET_WB, S_FLAG, S_ROW_RD, S_ROW_EMIT, S_BCD, S_ST_RD, S_ST_WR,
    S_LD_RD, S_LD_WR, S_EMIT
  } state_t;

  state_t    state_r, state_nxt;
  exec_cls_t cls;

  assign in_tready = (state_r == S_IDLE);
  assign cls       = cls_of(stat.opcode);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op = OP_ACCEPT;
          case (in_kind)
            KIND_LOAD: state_nxt = S_LOAD;
            KIND_EXEC: state_nxt = S_F_HI;
            KIND_TICK: state_nxt = S_TICK;
            default:   state_nxt = S_COLL;
          endcase
        end
      end
      S_LOAD: begin cmd.op = OP_LOAD; state_nxt = S_EMIT; end
      S_TICK: begin cmd.op = OP_TICK; state_nxt = S_EMIT; end
      S_COLL: begin cmd.op = OP_COLL; state_nxt = S_EMIT; end
      S_F_HI: begin cmd.op = OP_FETCH_HI; state_nxt = S_F_LO; end
      S_F_LO: begin cmd.op = OP_FETCH_LO; state_nxt = S_RD_X; end
      S_RD_X: begin cmd.op = OP_READ_X; state_nxt = S_RD_Y; end
      S_RD_Y: begin cmd.op = OP_READ_Y; state_nxt = S_EXEC; end
      S_EXEC: begin
        cmd.op = OP_EXEC;
        case (cls)
          CLS_RET:   state_nxt = stat.sp_zero ? S_EMIT : S_RET_WB;
          CLS_FLAG:  state_nxt = S_FLAG;
          CLS_DRAW:  state_nxt = S_ROW_RD;
          CLS_BCD:   state_nxt = S_BCD;
          CLS_STORE: state_nxt = S_ST_RD;
          CLS_LOADR: state_nxt = S_LD_RD;
          default:   state_nxt = S_EMIT;
        endcase
      end
      S_RET_WB: begin cmd.op = OP_RET_WB; state_nxt = S_EMIT; end
      S_FLAG:   begin cmd.op = OP_FLAG; state_nxt = S_EMIT; end
      S_ROW_RD: begin
        cmd.op = OP_ROW_RD;
        if (stat.out_free) state_nxt = S_ROW_EMIT;
      end
      S_ROW_EMIT: begin
        cmd.op    = OP_ROW_EMIT;
        state_nxt = stat.row_last ? S_IDLE : S_ROW_RD;
      end
      S_BCD: begin
        cmd.op = OP_BCD;
        if (stat.cnt_is_two) state_nxt = S_EMIT;
      end
      S_ST_RD: begin cmd.op = OP_STORE_RD; state_nxt = S_ST_WR; end
      S_ST_WR: begin
        cmd.op    = OP_STORE_WR;
        state_nxt = stat.cnt_is_x ? S_EMIT : S_ST_RD;
      end
      S_LD_RD: begin cmd.op = OP_LOADR_RD; state_nxt = S_LD_WR; end
      S_LD_WR: begin
        cmd.op    = OP_LOADR_WR;
        state_nxt = stat.cnt_is_x ? S_EMIT : S_LD_RD;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/chip8_dp.sv
// registers, memories, alu and result register of the chip8 interpreter core
module chip8_dp import chip8_pkg::*; #(
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     stat,
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  localparam int AW  = $clog2(MEM_BYTES);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [11:0]    addr_r, addr_nxt;
  logic [7:0]     ldata_r, ldata_nxt;
  logic [15:0]    keys_r, keys_nxt;
  logic [7:0]     rnd_r, rnd_nxt;
  logic [15:0]    op_r, op_nxt;
  logic [7:0]     vx_r, vx_nxt, vy_r, vy_nxt, flag_r, flag_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic [2:0]     ev_r, ev_nxt;
  logic           snd_r, snd_nxt;
  logic [15:0]    pc_r, pc_nxt, idx_r, idx_nxt;
  logic [7:0]     dt_r, dt_nxt, st_r, st_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [4:0]     held_r, held_nxt;
  logic [15:0]    vvalid_r, vvalid_nxt;
  logic           vld_q_r, vld_q_nxt;

  logic           ov_r, ov_nxt, olast_r, olast_nxt, osnd_r, osnd_nxt;
  logic [2:0]     oev_r, oev_nxt;
  logic [7:0]     orow_r, orow_nxt, odx_r, odx_nxt, ody_r, ody_nxt;
  logic [3:0]     orn_r, orn_nxt;
  logic [15:0]    opc_r, opc_nxt;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_q;
  logic           v_we;
  logic [3:0]     v_waddr, v_raddr;
  logic [7:0]     v_wdata, v_q, vq;
  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [15:0]    s_wdata, s_q;

  logic [3:0]     x, y, n;
  logic [7:0]     nn;
  logic [15:0]    nnn16, pc2, pc4, idx_cnt;
  logic [1:0]     hund;
  logic [7:0]     rem;
  logic [15:0]    tens_w;
  logic [7:0]     tens, ones, digit;
  logic [8:0]     sum9;
  logic [4:0]     first_key;

  chip8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_q)
  );

  chip8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_q)
  );

  chip8_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_q)
  );

  assign x       = op_r[11:8];
  assign y       = op_r[7:4];
  assign n       = op_r[3:0];
  assign nn      = op_r[7:0];
  assign nnn16   = {4'h0, op_r[11:0]};
  assign pc2     = pc_r + 16'd2;
  assign pc4     = pc_r + 16'd4;
  assign idx_cnt = idx_r + {12'h000, cnt_r};
  assign vq      = vld_q_r ? v_q : 8'h00;
  assign sum9    = {1'b0, vx_r} + {1'b0, vq};

  // decimal digits of vx
  assign hund   = (vx_r >= 8'd200) ? 2'd2 : ((vx_r >= 8'd100) ? 2'd1 : 2'd0);
  assign rem    = vx_r - 8'(hund * 8'd100);
  assign tens_w = (16'(rem) * 16'd205) >> 11;
  assign tens   = tens_w[7:0];
  assign ones   = rem - 8'(tens * 8'd10);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    digit = {6'h00, hund};
      2'd1:    digit = tens;
      default: digit = ones;
    endcase
  end

  always_comb begin
    first_key = NO_KEY;
    for (int i = 15; i >= 0; i--) begin
      if (keys_r[i]) first_key = 5'(i);
    end
  end

  assign stat.opcode     = op_r;
  assign stat.sp_zero    = (sp_r == '0);
  assign stat.cnt_is_x   = (cnt_r == x);
  assign stat.cnt_is_two = (cnt_r == 4'd2);
  assign stat.row_last   = (cnt_r == n - 4'd1);
  assign stat.out_free   = !ov_r || out_tready;

  always_comb begin
    addr_nxt = addr_r;  ldata_nxt = ldata_r; keys_nxt = keys_r; rnd_nxt = rnd_r;
    op_nxt   = op_r;    vx_nxt = vx_r;       vy_nxt = vy_r;     flag_nxt = flag_r;
    cnt_nxt  = cnt_r;   ev_nxt = ev_r;       snd_nxt = snd_r;   pc_nxt = pc_r;
    idx_nxt  = idx_r;   dt_nxt = dt_r;       st_nxt = st_r;     sp_nxt = sp_r;
    held_nxt = held_r;  vvalid_nxt = vvalid_r;
    ov_nxt   = ov_r && !out_tready;
    oev_nxt  = oev_r;   orow_nxt = orow_r;   orn_nxt = orn_r;   odx_nxt = odx_r;
    ody_nxt  = ody_r;   olast_nxt = olast_r; opc_nxt = opc_r;   osnd_nxt = osnd_r;
    mem_we   = 1'b0;
    mem_waddr = idx_cnt[AW-1:0];
    mem_wdata = digit;
    mem_raddr = idx_cnt[AW-1:0];
    v_we     = 1'b0;
    v_waddr  = x;
    v_wdata  = 8'h00;
    v_raddr  = cnt_r;
    s_we     = 1'b0;
    s_waddr  = sp_r[SAW-1:0];
    s_wdata  = pc2;
    s_raddr  = SAW'(sp_r - SPW'(1));

    case (cmd.op)
      OP_ACCEPT: begin
        addr_nxt  = in_tdata[11:0];
        ldata_nxt = in_tdata[19:12];
        keys_nxt  = in_tdata[35:20];
        rnd_nxt   = in_tdata[43:36];
        ev_nxt    = EV_DONE;
        snd_nxt   = 1'b0;
      end
      OP_LOAD: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(addr_r);
        mem_wdata = ldata_r;
      end
      OP_TICK: begin
        if (dt_r != 8'h00) dt_nxt = dt_r - 8'd1;
        if (st_r != 8'h00) begin
          st_nxt  = st_r - 8'd1;
          snd_nxt = 1'b1;
        end
      end
      OP_COLL: begin
        v_we    = 1'b1;
        v_waddr = REG_F;
        v_wdata = {7'h00, ldata_r[0]};
      end
      OP_FETCH_HI: mem_raddr = pc_r[AW-1:0];
      OP_FETCH_LO: begin
        mem_raddr = AW'(pc_r + 16'd1);
        op_nxt    = {mem_q, op_r[7:0]};
      end
      OP_READ_X: begin
        op_nxt  = {op_r[15:8], mem_q};
        v_raddr = op_r[11:8];
      end
      OP_READ_Y: begin
        vx_nxt  = vq;
        v_raddr = (op_r[15:12] == 4'hB) ? 4'h0 : y;
      end
      OP_EXEC: begin
        vy_nxt  = vq;
        pc_nxt  = pc2;
        cnt_nxt = 4'h0;
        case (op_r[15:12])
          4'h0: begin
            if (op_r == OPC_CLS) begin
              ev_nxt = EV_CLS;
            end else if (op_r == OPC_RET) begin
              if (sp_r == '0) ev_nxt = EV_STACK;
              else sp_nxt = sp_r - SPW'(1);
            end
          end
          4'h1: pc_nxt = nnn16;
          4'h2: begin
            if (sp_r >= SPW'(STACK_DEPTH)) begin
              ev_nxt = EV_STACK;
            end else begin
              s_we   = 1'b1;
              sp_nxt = sp_r + SPW'(1);
              pc_nxt = nnn16;
            end
          end
          4'h3: if (vx_r == nn) pc_nxt = pc4;
          4'h4: if (vx_r != nn) pc_nxt = pc4;
          4'h5: if (vx_r == vq) pc_nxt = pc4;
          4'h6: begin v_we = 1'b1; v_wdata = nn; end
          4'h7: begin v_we = 1'b1; v_wdata = vx_r + nn; end
          4'h8: begin
            v_we = 1'b1;
            case (n)
              4'h0: v_wdata = vq;
              4'h1: v_wdata = vx_r | vq;
              4'h2: v_wdata = vx_r & vq;
              4'h3: v_wdata = vx_r ^ vq;
              4'h4: begin v_wdata = sum9[7:0]; flag_nxt = {7'h00, sum9[8]}; end
              4'h5: begin v_wdata = vx_r - vq; flag_nxt = {7'h00, vx_r >= vq}; end
              4'h6: begin v_wdata = vx_r >> 1; flag_nxt = {7'h00, vx_r[0]}; end
              4'h7: begin v_wdata = vq - vx_r; flag_nxt = {7'h00, vq >= vx_r}; end
              4'hE: begin v_wdata = vx_r << 1; flag_nxt = {7'h00, vx_r[7]}; end
              default: v_we = 1'b0;
            endcase
          end
          4'h9: if (vx_r != vq) pc_nxt = pc4;
          4'hA: idx_nxt = nnn16;
          4'hB: pc_nxt = nnn16 + {8'h00, vq};
          4'hC: begin v_we = 1'b1; v_wdata = rnd_r & nn; end
          4'hD: begin
            if (n != 4'h0) begin
              v_we    = 1'b1;
              v_waddr = REG_F;
            end
          end
          4'hE: begin
            if ((nn == FN_SKP && keys_r[vx_r[3:0]]) ||
                (nn == FN_SKNP && !keys_r[vx_r[3:0]])) pc_nxt = pc4;
          end
          4'hF: begin
            case (nn)
              FN_GDLY: begin v_we = 1'b1; v_wdata = dt_r; end
              FN_KEY: begin
                if (held_r[4]) begin
                  held_nxt = first_key;
                  pc_nxt   = pc_r;
                  ev_nxt   = EV_WAIT;
                end else if (keys_r[held_r[3:0]]) begin
                  pc_nxt = pc_r;
                  ev_nxt = EV_WAIT;
                end else begin
                  v_we     = 1'b1;
                  v_wdata  = {4'h0, held_r[3:0]};
                  held_nxt = NO_KEY;
                end
              end
              FN_SDLY: dt_nxt = vx_r;
              FN_SSND: st_nxt = vx_r;
              FN_ADDI: idx_nxt = idx_r + {8'h00, vx_r};
              FN_FONT: idx_nxt = {12'h000, vx_r[3:0]} * 16'd5;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      OP_RET_WB: pc_nxt = s_q;
      OP_FLAG: begin
        v_we    = 1'b1;
        v_waddr = REG_F;
        v_wdata = flag_r;
      end
      OP_ROW_RD: ;
      OP_ROW_EMIT: begin
        ov_nxt    = 1'b1;
        oev_nxt   = EV_ROW;
        orow_nxt  = mem_q;
        orn_nxt   = cnt_r;
        odx_nxt   = vx_r;
        ody_nxt   = vy_r;
        olast_nxt = (cnt_r == n - 4'd1);
        opc_nxt   = pc_r;
        osnd_nxt  = 1'b0;
        cnt_nxt   = cnt_r + 4'd1;
      end
      OP_BCD: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
      end
      OP_STORE_RD: v_raddr = cnt_r;
      OP_STORE_WR: begin
        mem_we    = 1'b1;
        mem_wdata = vq;
        cnt_nxt   = cnt_r + 4'd1;
      end
      OP_LOADR_RD: ;
      OP_LOADR_WR: begin
        v_we    = 1'b1;
        v_waddr = cnt_r;
        v_wdata = mem_q;
        cnt_nxt = cnt_r + 4'd1;
      end
      OP_EMIT: begin
        ov_nxt    = 1'b1;
        oev_nxt   = ev_r;
        orow_nxt  = 8'h00;
        orn_nxt   = 4'h0;
        odx_nxt   = 8'h00;
        ody_nxt   = 8'h00;
        olast_nxt = 1'b1;
        opc_nxt   = pc_r;
        osnd_nxt  = snd_r;
      end
      default: ;
    endcase

    vld_q_nxt = vvalid_r[v_raddr];
    if (v_we) vvalid_nxt[v_waddr] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= PC_RESET;
      idx_r    <= 16'h0000;
      dt_r     <= 8'h00;
      st_r     <= 8'h00;
      sp_r     <= '0;
      held_r   <= NO_KEY;
      vvalid_r <= 16'h0000;
      ov_r     <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      idx_r    <= idx_nxt;
      dt_r     <= dt_nxt;
      st_r     <= st_nxt;
      sp_r     <= sp_nxt;
      held_r   <= held_nxt;
      vvalid_r <= vvalid_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;  ldata_r <= ldata_nxt; keys_r <= keys_nxt; rnd_r  <= rnd_nxt;
    op_r    <= op_nxt;    vx_r    <= vx_nxt;    vy_r   <= vy_nxt;   flag_r <= flag_nxt;
    cnt_r   <= cnt_nxt;   ev_r    <= ev_nxt;    snd_r  <= snd_nxt;  vld_q_r <= vld_q_nxt;
    oev_r   <= oev_nxt;   orow_r  <= orow_nxt;  orn_r  <= orn_nxt;  odx_r  <= odx_nxt;
    ody_r   <= ody_nxt;   olast_r <= olast_nxt; opc_r  <= opc_nxt;  osnd_r <= osnd_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = oev_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {3'b000, osnd_r, opc_r, ody_r, odx_r, orn_r, orow_r};

endmodule

// File: bench/tb_chip8_cpu_core.sv
// testbench for the chip8 interpreter core: directed and random programs against a predictor
module tb_chip8_cpu_core;
  import chip8_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  row_byte;
    logic [3:0]  row_num;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic        last;
    logic [15:0] pc;
    logic        snd;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  chip8_cpu_core uut (.*);

  logic [7:0]  vreg [16];
  logic [15:0] ireg;
  logic [15:0] pc_q;
  logic [7:0]  dtimer;
  logic [7:0]  stimer;
  int          sp;
  logic [15:0] rstack [16];
  logic [4:0]  key_q;
  logic [7:0]  mem [4096];
  bit          written [4096];
  result_t     expected_results [$];
  int          errors;
  int          rx_stall_max;
  int          rx_hold;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void push_result(input logic [2:0] ev, input logic [7:0] rb,
                                      input logic [3:0] rn, input logic [7:0] dx,
                                      input logic [7:0] dy, input logic last,
                                      input logic snd);
    result_t r;
    r = '{ev, rb, rn, dx, dy, last, pc_q, snd};
    expected_results.push_back(r);
  endfunction

  function automatic logic [7:0] rd(input logic [15:0] a);
    return mem[a[11:0]];
  endfunction

  function automatic void wr(input logic [15:0] a, input logic [7:0] v);
    mem[a[11:0]] = v;
    written[a[11:0]] = 1;
  endfunction

  // model one core request and queue its results
  function automatic void predict_core(input logic [1:0] kind, input logic [11:0] la,
                                       input logic [7:0] ld, input logic [15:0] keys,
                                       input logic [7:0] rnd);
    logic [15:0] op;
    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy;
    logic [8:0]  sum;
    logic [2:0]  ev;
    logic        snd;
    snd = 0;
    ev = EV_DONE;
    if (kind == KIND_LOAD) wr({4'h0, la}, ld);
    else if (kind == KIND_TICK) begin
      if (dtimer > 0) dtimer--;
      if (stimer > 0) begin stimer--; snd = 1; end
    end else if (kind == KIND_COLL) vreg[15] = {7'd0, ld[0]};
    else begin
      op = {rd(pc_q), rd(pc_q + 16'd1)};
      x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0];
      vx = vreg[x]; vy = vreg[y];
      pc_q = pc_q + 16'd2;
      case (op[15:12])
        4'h0: if (op == OPC_CLS) ev = EV_CLS;
              else if (op == OPC_RET) begin
                if (sp == 0) ev = EV_STACK;
                else begin sp--; pc_q = rstack[sp]; end
              end
        4'h1: pc_q = {4'h0, op[11:0]};
        4'h2: if (sp >= 16) ev = EV_STACK;
              else begin rstack[sp] = pc_q; sp++; pc_q = {4'h0, op[11:0]}; end
        4'h3: if (vx == nn) pc_q += 16'd2;
        4'h4: if (vx != nn) pc_q += 16'd2;
        4'h5: if (vx == vy) pc_q += 16'd2;
        4'h6: vreg[x] = nn;
        4'h7: vreg[x] = vx + nn;
        4'h8: case (n)
          4'h0: vreg[x] = vy;
          4'h1: vreg[x] = vx | vy;
          4'h2: vreg[x] = vx & vy;
          4'h3: vreg[x] = vx ^ vy;
          4'h4: begin sum = vx + vy; vreg[x] = sum[7:0]; vreg[15] = {7'd0, sum[8]}; end
          4'h5: begin vreg[x] = vx - vy; vreg[15] = {7'd0, vx >= vy}; end
          4'h6: begin vreg[x] = vx >> 1; vreg[15] = {7'd0, vx[0]}; end
          4'h7: begin vreg[x] = vy - vx; vreg[15] = {7'd0, vy >= vx}; end
          4'hE: begin vreg[x] = vx << 1; vreg[15] = {7'd0, vx[7]}; end
          default: ;
        endcase
        4'h9: if (vx != vy) pc_q += 16'd2;
        4'hA: ireg = {4'h0, op[11:0]};
        4'hB: pc_q = {4'h0, op[11:0]} + {8'h0, vreg[0]};
        4'hC: vreg[x] = rnd & nn;
        4'hD: if (n != 0) begin
          vreg[15] = 0;
          for (int i = 0; i < n; i++)
            push_result(EV_ROW, rd(ireg + 16'(i)), 4'(i), vx, vy, i + 1 == n, 0);
          return;
        end
        4'hE: begin
          if (nn == FN_SKP && keys[vx[3:0]]) pc_q += 16'd2;
          else if (nn == FN_SKNP && !keys[vx[3:0]]) pc_q += 16'd2;
        end
        4'hF: case (nn)
          FN_GDLY: vreg[x] = dtimer;
          FN_KEY: begin
            if (key_q == NO_KEY) begin
              for (int i = 15; i >= 0; i--) if (keys[i]) key_q = 5'(i);
              pc_q -= 16'd2; ev = EV_WAIT;
            end else if (keys[key_q[3:0]]) begin
              pc_q -= 16'd2; ev = EV_WAIT;
            end else begin
              vreg[x] = {3'd0, key_q}; key_q = NO_KEY;
            end
          end
          FN_SDLY: dtimer = vx;
          FN_SSND: stimer = vx;
          FN_ADDI: ireg = ireg + {8'h0, vx};
          FN_FONT: ireg = {8'h0, vx[3:0]} * 16'd5;
          FN_BCD: begin
            wr(ireg, vx / 100); wr(ireg + 16'd1, (vx / 10) % 10); wr(ireg + 16'd2, vx % 10);
          end
          FN_STORE: for (int i = 0; i <= x; i++) wr(ireg + 16'(i), vreg[i]);
          FN_LOADR: for (int i = 0; i <= x; i++) vreg[i] = rd(ireg + 16'(i));
          default: ;
        endcase
        default: ;
      endcase
    end
    push_result(ev, 0, 0, 0, 0, 1, snd);
  endfunction

  task automatic idle_gap(input int long_pct);
    int g;
    g = ($urandom_range(99) < long_pct) ? $urandom_range(40, 10) : $urandom_range(2);
    repeat (g) @(posedge clk);
  endtask

  task automatic send_request(input logic [1:0] kind, input logic [11:0] la,
                              input logic [7:0] ld, input logic [15:0] keys,
                              input logic [7:0] rnd, input bit gaps);
    if (gaps && $urandom_range(2) == 0) idle_gap(5);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {rnd, keys, ld, la};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_core(kind, la, ld, keys, rnd);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // instruction words are stored big-endian at the current pc
  task automatic load_word(input logic [11:0] a, input logic [15:0] w, input bit gaps);
    send_request(KIND_LOAD, a, w[15:8], 0, 0, gaps);
    send_request(KIND_LOAD, a + 12'd1, w[7:0], 0, 0, gaps);
  endtask

  task automatic exec_word(input logic [15:0] w, input logic [15:0] keys, input bit gaps);
    load_word(pc_q[11:0], w, gaps);
    send_request(KIND_EXEC, 0, 0, keys, 8'($urandom), gaps);
  endtask

  task automatic drain;
    int t;
    t = 0;
    while (expected_results.size() != 0 && t < 20000) begin @(posedge clk); t++; end
    repeat (40) @(posedge clk);
  endtask

  // keep reads of memory at index on written bytes
  task automatic fill_index(input int cnt, input bit gaps);
    for (int i = 0; i < cnt; i++)
      if (!written[(ireg + 16'(i)) % 4096])
        send_request(KIND_LOAD, 12'(ireg + 16'(i)), 8'($urandom), 0, 0, gaps);
  endtask

  task automatic test_directed;
    exec_word(16'h6000, 0, 0);
    exec_word(16'h6FFF, 0, 0);
    exec_word(16'h61FF, 0, 0);
    exec_word(16'h8F14, 0, 0);
    exec_word(16'h6101, 0, 0);
    exec_word(16'h8015, 0, 0);
    exec_word(16'h810E, 0, 0);
    exec_word(16'h8107, 0, 0);
    exec_word(16'h8106, 0, 0);
    exec_word(OPC_CLS, 0, 0);
    exec_word(OPC_RET, 0, 0);
    exec_word(16'hA300, 0, 0);
    fill_index(15, 0);
    exec_word(16'hD01F, 0, 0);
    send_request(KIND_COLL, 0, 8'hFF, 0, 0, 0);
    exec_word(16'hD010, 0, 0);
    exec_word(16'h5FFF, 0, 0);
    exec_word(16'h6A05, 0, 0);
    exec_word(16'hFA0A, 16'hFFFF, 0);
    exec_word(16'hFA0A, 16'h0000, 0);
    exec_word(16'hFA18, 0, 0);
    repeat (7) send_request(KIND_TICK, 0, 0, 0, 0, 0);
    exec_word(16'h0123, 0, 0);
  endtask

  task automatic test_stack;
    for (int i = 0; i < 17; i++) exec_word({4'h2, 12'h400 + 12'(i * 16)}, 0, 1);
    for (int i = 0; i < 17; i++) exec_word(OPC_RET, 0, 1);
    exec_word(16'h1200, 0, 1);
  endtask

  function automatic logic [15:0] random_opcode;
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(9))
      0: w = {4'hF, w[11:8], FN_ADDI};
      1: w = {4'hF, w[11:8], FN_BCD};
      2: w = {4'hF, w[11:8], FN_STORE};
      3: w = {4'hF, w[11:8], FN_LOADR};
      4: w = {4'hF, w[11:8], $urandom_range(1) ? FN_GDLY : FN_SDLY};
      5: w = {4'hE, w[11:8], $urandom_range(1) ? FN_SKP : FN_SKNP};
      6: w = {4'h8, w[11:4], 4'($urandom_range(1) ? 14 : $urandom_range(7))};
      7: w = {4'hF, w[11:8], $urandom_range(1) ? FN_FONT : FN_SSND};
      default: ;
    endcase
    // jumps, calls, returns and key waits become 7XNN; calls, returns and key waits have their own tests
    if (w[15:12] inside {4'h1, 4'h2, 4'hB} || w == OPC_RET ||
        w[7:0] == FN_KEY && w[15:12] == 4'hF)
      w = {4'h7, w[11:0]};
    return w;
  endfunction

  task automatic test_random;
    logic [15:0] w;
    int k;
    k = 0;
    while (k < 120) begin
      w = random_opcode();
      if (w[15:12] == 4'hD) fill_index(w[3:0], 1);
      if (w[15:12] == 4'hF && w[7:0] == FN_LOADR) fill_index(w[11:8] + 1, 1);
      case ($urandom_range(9))
        0: begin send_request(KIND_TICK, 0, 0, 0, 0, 1); k++; end
        1: begin send_request(KIND_COLL, 0, 8'($urandom), 0, 0, 1); k++; end
        default: begin exec_word(w, 16'($urandom), 1); k += 3; end
      endcase
      if (pc_q > 16'h0F00) exec_word(16'h1200, 0, 1);
      if (k % 100 < 3) drain();
    end
  endtask

  task automatic test_key_wait;
    exec_word(16'hF30A, 16'h8040, 1);
    send_request(KIND_EXEC, 0, 0, 16'h0040, 0, 1);
    send_request(KIND_EXEC, 0, 0, 16'h0000, 0, 1);
  endtask

  always @(posedge clk) begin
    result_t g, e;
    if (!rst_n) out_tready <= 1'b0;
    else begin
      if (out_tvalid && out_tready) begin
        g = '{out_tuser, out_tdata[7:0], out_tdata[11:8], out_tdata[19:12],
              out_tdata[27:20], out_tlast, out_tdata[43:28], out_tdata[44]};
        if (expected_results.size() == 0) report("unexpected result", g, 0);
        else begin
          e = expected_results.pop_front();
          if (g.ev != e.ev) report("event", g.ev, e.ev);
          if (g.row_byte != e.row_byte) report("row byte", g.row_byte, e.row_byte);
          if (g.row_num != e.row_num) report("row number", g.row_num, e.row_num);
          if (g.dx != e.dx) report("draw x", g.dx, e.dx);
          if (g.dy != e.dy) report("draw y", g.dy, e.dy);
          if (g.last != e.last) report("last", g.last, e.last);
          if (g.pc != e.pc) report("pc", g.pc, e.pc);
          if (g.snd != e.snd) report("sound", g.snd, e.snd);
        end
      end
      if (rx_stall_max == 0) out_tready <= 1'b1;
      else if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if ($urandom_range(99) == 0) begin
        rx_hold = $urandom_range(40, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) < 3) ? 1'b0 : ($urandom_range(3) != 0);
      end
    end
  end

  initial begin
    errors = 0;
    rx_stall_max = 0;
    rx_hold = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    for (int i = 0; i < 16; i++) vreg[i] = 0;
    ireg = 0; pc_q = PC_RESET; dtimer = 0; stimer = 0; sp = 0; key_q = NO_KEY;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    rx_stall_max = 1;
    test_stack();
    test_key_wait();
    drain();
    test_random();
    drain();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
